>>> rtl/cir_pkg.sv
// Shared types and constants for the cubic interpolating resampler.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package cir_pkg;

  // Audio word width, Q1.23.
  localparam int SAMPLE_BITS = 24;
  // Fraction bits of the interpolation weight.
  localparam int T_BITS = 16;

  // Datapath widths of one lane; each holds the worst case for full-scale inputs.
  localparam int COEF3_W = SAMPLE_BITS + 3;
  localparam int COEF2_W = SAMPLE_BITS + 4;
  localparam int COEF1_W = SAMPLE_BITS + 1;
  localparam int OP_W    = SAMPLE_BITS + 5;
  localparam int PROD_W  = OP_W + T_BITS + 1;
  localparam int Y_W     = SAMPLE_BITS + 5;

  // Configuration registers.
  localparam int CFG_IDX_W  = 4;
  localparam int RATIO_W    = 28;
  localparam int CFG_DATA_W = RATIO_W;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_STEP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_THROUGH = 4'd1;
  localparam logic [RATIO_W-1:0]   RATIO_RESET      = 28'h100_0000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } cir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          last_of_run;
  } cir_out_t;

  // Which Horner step the shared multiplier performs.
  typedef enum logic [1:0] {
    PH_C3 = 2'd0,
    PH_C2 = 2'd1,
    PH_C1 = 2'd2
  } cir_phase_e;

  typedef struct packed {
    logic       push;
    logic       coef_load;
    logic       mul_en;
    cir_phase_e phase;
  } cir_lane_ctl_t;

  typedef struct packed {
    logic load;
    logic pass;
    logic last;
  } cir_emit_t;

endpackage

`default_nettype wire

>>> rtl/cubic_interpolating_resampler_unit.sv
// Top level of the stereo Catmull-Rom resampler: control sequencer, two lanes
// and the merging stage. Depends on cir_pkg, cir_lane and cir_merge.
`default_nettype none

// Each input transfer carries one stereo sample at the core rate, which is shifted
// into a four-deep history per channel. The block then produces zero or more
// output transfers: each is a Catmull-Rom cubic through the history, evaluated at
// the fractional part of a read offset, after which the offset advances by
// ratio_step (unsigned, FRAC_BITS fraction bits). Outputs stop once the offset
// reaches 1.0, and one whole unit is taken off; at most MAX_UPSAMPLE outputs come
// from one input, and if that cap is hit below 1.0 the offset is cleared. The
// final output of a run has last_of_run set. With pass_through set, every input
// comes back as exactly one output, unchanged, with last_of_run set, and the
// offset holds. The block handles one input at a time. For an input that gives
// interpolated outputs it takes the transfer, then for each output makes one
// decision, runs the three Horner steps on the lane multiplier and hands the
// result to the output register, and closes with one more decision. A
// pass-through input is taken and then handed over. The single multiplier in
// each lane serves all three steps, and both lanes run in lockstep. A stalled
// output register holds the sequencer in its hand-off state. Configuration
// is written through cfg_we_i, cfg_index_i and cfg_data_i (index 0: ratio_step,
// index 1: pass_through, other indexes ignored) and should change only while idle.
module cubic_interpolating_resampler_unit #(
  parameter int FRAC_BITS    = 24,
  parameter int MAX_UPSAMPLE = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cir_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [cir_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire cir_pkg::cir_in_t                   in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output cir_pkg::cir_out_t                       out_data_o
);

  localparam int OFF_W = 32;
  localparam int N_W   = $clog2(MAX_UPSAMPLE + 1);
  localparam int TW    = FRAC_BITS + cir_pkg::T_BITS;
  localparam logic [OFF_W-1:0] ONE_UNIT = OFF_W'(1) << FRAC_BITS;
  localparam logic [N_W-1:0]   N_MAX    = N_W'(MAX_UPSAMPLE);
  localparam logic [N_W-1:0]   N_LAST   = N_W'(MAX_UPSAMPLE - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PASS  = 5'b00010,
    S_CHECK = 5'b00100,
    S_MUL   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  cir_pkg::cir_phase_e         phase_q, phase_d;
  logic [OFF_W-1:0]            off_q, off_d, next_off;
  logic [N_W-1:0]              n_q, n_d;
  logic [cir_pkg::RATIO_W-1:0] ratio_q;
  logic                        pass_q;

  logic                        in_fire;
  logic                        merge_free;
  logic [TW-1:0]               t_wide;
  logic [cir_pkg::T_BITS-1:0]  t;
  cir_pkg::cir_lane_ctl_t      lane_ctl;
  cir_pkg::cir_emit_t          emit;

  logic signed [cir_pkg::Y_W-1:0]         left_y, right_y;
  logic signed [cir_pkg::SAMPLE_BITS-1:0] left_new, right_new;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= cir_pkg::RATIO_RESET;
      pass_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cir_pkg::CFG_RATIO_STEP:   ratio_q <= cfg_data_i[cir_pkg::RATIO_W-1:0];
        cir_pkg::CFG_PASS_THROUGH: pass_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // The weight is the fraction of the offset cut to T_BITS fraction bits.
  assign t_wide   = {off_q[FRAC_BITS-1:0], {cir_pkg::T_BITS{1'b0}}};
  assign t        = t_wide[TW-1 -: cir_pkg::T_BITS];
  assign next_off = off_q + OFF_W'(ratio_q);

  // Sequencer: one decision per output, three Horner steps, then hand-off.
  always_comb begin
    state_d            = state_q;
    phase_d            = phase_q;
    off_d              = off_q;
    n_d                = n_q;
    lane_ctl.push      = in_fire;
    lane_ctl.coef_load = (state_q == S_CHECK);
    lane_ctl.mul_en    = (state_q == S_MUL);
    lane_ctl.phase     = phase_q;
    emit.load          = 1'b0;
    emit.pass          = (state_q == S_PASS);
    emit.last          = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = pass_q ? S_PASS : S_CHECK;
        end
      end
      S_PASS: begin
        if (merge_free) begin
          emit.load = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_CHECK: begin
        if (off_q < ONE_UNIT && n_q < N_MAX) begin
          phase_d = cir_pkg::PH_C3;
          state_d = S_MUL;
        end else begin
          off_d   = (off_q >= ONE_UNIT) ? off_q - ONE_UNIT : '0;
          n_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        case (phase_q)
          cir_pkg::PH_C3: phase_d = cir_pkg::PH_C2;
          cir_pkg::PH_C2: phase_d = cir_pkg::PH_C1;
          default:        state_d = S_EMIT;
        endcase
      end
      S_EMIT: begin
        // The run ends when this step crosses 1.0 or the cap is reached.
        emit.last = (next_off >= ONE_UNIT) || (n_q == N_LAST);
        if (merge_free) begin
          emit.load = 1'b1;
          off_d     = next_off;
          n_d       = n_q + N_W'(1);
          state_d   = S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= cir_pkg::PH_C3;
      off_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      off_q   <= off_d;
      n_q     <= n_d;
    end
  end

  cir_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .sample_i (in_data_i.left_sample),
    .t_i      (t),
    .y_o      (left_y),
    .newest_o (left_new)
  );

  cir_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lane_ctl),
    .sample_i (in_data_i.right_sample),
    .t_i      (t),
    .y_o      (right_y),
    .newest_o (right_new)
  );

  cir_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .left_y_i    (left_y),
    .right_y_i   (right_y),
    .left_raw_i  (left_new),
    .right_raw_i (right_new),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .free_o      (merge_free)
  );

  // A result is only handed over when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit.load |-> merge_free)
    else $error("result loaded into an occupied output register");

  // The output count of one input never passes the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= N_MAX)
    else $error("output count beyond cap");

  // Interpolation only runs while the offset is below one unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_MUL) |-> (off_q < ONE_UNIT))
    else $error("interpolating at an offset of one unit or more");

  // A pass-through input gives exactly one result and frees the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_PASS && merge_free) |=> (state_q == S_IDLE))
    else $error("pass-through did not complete");

  // The count is back at zero whenever a new input can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_IDLE) |-> (n_q == '0))
    else $error("stale output count while idle");

endmodule

`default_nettype wire

>>> rtl/cir_lane.sv
// One channel lane: four-sample history, Catmull-Rom coefficients and a shared
// multiplier that evaluates the cubic in Horner form. Depends on cir_pkg.
`default_nettype none

module cir_lane (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire cir_pkg::cir_lane_ctl_t                 ctl_i,
  input  wire logic signed [cir_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic        [cir_pkg::T_BITS-1:0]      t_i,
  output logic signed      [cir_pkg::Y_W-1:0]         y_o,
  output logic signed      [cir_pkg::SAMPLE_BITS-1:0] newest_o
);

  localparam int SB = cir_pkg::SAMPLE_BITS;
  localparam int PW = cir_pkg::PROD_W;
  localparam logic [PW-1:0] RND_ONE = PW'(1) << cir_pkg::T_BITS;

  logic signed [SB-1:0] hist_q [4];

  logic signed [cir_pkg::COEF3_W-1:0] c3_q, c3_d;
  logic signed [cir_pkg::COEF2_W-1:0] c2_q, c2_d;
  logic signed [cir_pkg::COEF1_W-1:0] c1_q, c1_d;
  logic signed [cir_pkg::COEF2_W-1:0] e0, e1, e2, e3, dif12;
  logic signed [cir_pkg::OP_W-1:0]    op;
  logic signed [PW-1:0]               prod_q, prod_d, rnd_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        hist_q[i] <= '0;
      end
    end else if (ctl_i.push) begin
      hist_q[0] <= hist_q[1];
      hist_q[1] <= hist_q[2];
      hist_q[2] <= hist_q[3];
      hist_q[3] <= sample_i;
    end
  end

  // Coefficients from the history, in a width that holds every partial sum.
  always_comb begin
    e0    = cir_pkg::COEF2_W'(hist_q[0]);
    e1    = cir_pkg::COEF2_W'(hist_q[1]);
    e2    = cir_pkg::COEF2_W'(hist_q[2]);
    e3    = cir_pkg::COEF2_W'(hist_q[3]);
    dif12 = e1 - e2;
    c3_d  = cir_pkg::COEF3_W'((dif12 <<< 1) + dif12 + e3 - e0);
    c2_d  = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    c1_d  = cir_pkg::COEF1_W'(e2 - e0);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.coef_load) begin
      c3_q <= c3_d;
      c2_q <= c2_d;
      c1_q <= c1_d;
    end
  end

  // Horner step: the previous product, floored by 2^T_BITS, joins the next coefficient.
  always_comb begin
    case (ctl_i.phase)
      cir_pkg::PH_C3: op = cir_pkg::OP_W'(c3_q);
      cir_pkg::PH_C2: op = cir_pkg::OP_W'(c2_q)
                           + cir_pkg::OP_W'(prod_q >>> cir_pkg::T_BITS);
      cir_pkg::PH_C1: op = cir_pkg::OP_W'(c1_q)
                           + cir_pkg::OP_W'(prod_q >>> cir_pkg::T_BITS);
      default:        op = '0;
    endcase
    prod_d = op * $signed({1'b0, t_i});
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Final step rounds half up and adds the second history entry.
  always_comb begin
    rnd_sum = prod_q + $signed(RND_ONE);
    y_o     = cir_pkg::Y_W'(hist_q[1]) + cir_pkg::Y_W'(rnd_sum >>> (cir_pkg::T_BITS + 1));
  end

  assign newest_o = hist_q[3];

endmodule

`default_nettype wire

>>> rtl/cir_merge.sv
// Merging stage: saturates the two lane results (raw samples in pass-through), joins
// them with the run marker and holds the output register. Depends on cir_pkg.
`default_nettype none

module cir_merge (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire cir_pkg::cir_emit_t                     emit_i,
  input  wire logic signed [cir_pkg::Y_W-1:0]         left_y_i,
  input  wire logic signed [cir_pkg::Y_W-1:0]         right_y_i,
  input  wire logic signed [cir_pkg::SAMPLE_BITS-1:0] left_raw_i,
  input  wire logic signed [cir_pkg::SAMPLE_BITS-1:0] right_raw_i,
  input  wire logic                                   out_stall_i,
  output logic                                        out_valid_o,
  output cir_pkg::cir_out_t                           out_data_o,
  output logic                                        free_o
);

  localparam int SB = cir_pkg::SAMPLE_BITS;
  localparam int YW = cir_pkg::Y_W;
  localparam logic signed [YW-1:0] SAT_HI = YW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [YW-1:0] SAT_LO = -SAT_HI - YW'(1);

  function automatic logic signed [SB-1:0] sat(input logic signed [YW-1:0] y);
    logic signed [YW-1:0] c;
    c = y;
    if (y > SAT_HI) begin
      c = SAT_HI;
    end else if (y < SAT_LO) begin
      c = SAT_LO;
    end
    return SB'(c);
  endfunction

  logic              valid_q;
  cir_pkg::cir_out_t out_q, out_d;

  always_comb begin
    if (emit_i.pass) begin
      out_d.left_out  = left_raw_i;
      out_d.right_out = right_raw_i;
    end else begin
      out_d.left_out  = sat(left_y_i);
      out_d.right_out = sat(right_y_i);
    end
    out_d.last_of_run = emit_i.last;
  end

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> sim/cubic_interpolating_resampler_unit_test.sv
// Self-checking testbench for cubic_interpolating_resampler_unit: a directed stimulus table
// followed by random stereo samples, scored against an in-bench Catmull-Rom predictor
// or against results written in the table. Depends on cir_pkg and the RTL in rtl/.
`timescale 1ns / 1ps

module cubic_interpolating_resampler_unit_test;
  import cir_pkg::*;

  localparam int FRAC_BITS    = 24;
  localparam int MAX_UPSAMPLE = 8;

  // Longest busy stretch of the block for one input, at the output cap, with margin.
  // Used before configuration writes and at the end of the run.
  localparam int SETTLE_CYCLES = 2 + 5 * MAX_UPSAMPLE + 8;
  // Generous ceiling on the cycle count of the whole run.
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [RATIO_W-1:0] RATIO_LOW  = 28'd2097152;    // 0.125, eight outputs per input
  localparam logic [RATIO_W-1:0] RATIO_HIGH = 28'd268435455;  // just under 16.0
  localparam logic [RATIO_W-1:0] RATIO_SLOW = 28'd1000000;    // below range, hits the cap

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HIGH = 4'd15;

  typedef logic signed [SAMPLE_BITS-1:0] audio_t;

  localparam audio_t FULL_POS = 24'sh7FFFFF;
  localparam audio_t FULL_NEG = 24'sh800000;
  localparam audio_t ZERO     = 24'sh000000;
  localparam audio_t MINUS1   = 24'shFFFFFF;

  // Directed stimulus table. A row either writes a register, sends a sample that is scored
  // against the predictor, or sends a sample whose single result is written out in the row.
  typedef enum logic [1:0] {
    ROW_CONFIG,
    ROW_SAMPLE,
    ROW_KNOWN
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
    cir_in_t               sample;
    cir_out_t              known;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  cir_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cir_out_t              out_data;

  // Predictor state: history per channel (index 0 oldest), read offset and the registers.
  audio_t             hist_left [4];
  audio_t             hist_right[4];
  logic [31:0]        read_offset;
  logic [RATIO_W-1:0] ratio_step;
  logic               pass_through;
  cir_out_t           run_outputs[MAX_UPSAMPLE];

  // Expected output transfers, oldest first.
  cir_out_t  expected_outputs[$];
  cir_out_t  oldest_expected;
  stim_row_t directed_rows[$];

  int errors          = 0;
  int cycle_count     = 0;
  int samples_sent    = 0;
  int outputs_checked = 0;
  int register_writes = 0;
  int drain_pauses    = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;

  // Sender and receiver idling for the three random phases.
  int sender_idle_by_phase[3] = '{13, 74, 0};
  int stall_by_phase[3]       = '{74, 13, 0};

  cubic_interpolating_resampler_unit #(
    .FRAC_BITS   (FRAC_BITS),
    .MAX_UPSAMPLE(MAX_UPSAMPLE)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Catmull-Rom cubic through p0..p3 at weight t (T_BITS fraction bits), evaluated in
  // Horner form with floor at every scaling step and a rounded final step. Arithmetic
  // right shifts of signed 64-bit values give the floor directly.
  function automatic audio_t catmull_rom(input audio_t p[4], input longint t);
    longint p0, p1, p2, p3;
    longint c3, c2, c1, a, b, y;
    p0 = p[0];
    p1 = p[1];
    p2 = p[2];
    p3 = p[3];
    c3 = 3 * (p1 - p2) + p3 - p0;
    c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c1 = p2 - p0;
    a  = c2 + ((c3 * t) >>> T_BITS);
    b  = c1 + ((a * t) >>> T_BITS);
    y  = p1 + ((b * t + (longint'(1) << T_BITS)) >>> (T_BITS + 1));
    // Saturate to the signed sample range.
    if (y > longint'(FULL_POS)) begin
      y = longint'(FULL_POS);
    end else if (y < longint'(FULL_NEG)) begin
      y = longint'(FULL_NEG);
    end
    return y[SAMPLE_BITS-1:0];
  endfunction

  // Advances the predicted resampler by one core-rate sample. The outputs it causes are left
  // in run_outputs; the return value is how many there are.
  function automatic int resample_sample(input cir_in_t s);
    longint unsigned one_unit;
    longint unsigned offset;
    longint unsigned frac;
    longint          t;
    int              n;
    int              k;
    one_unit = longint'(1) << FRAC_BITS;
    offset   = read_offset;
    n        = 0;
    for (k = 0; k < 3; k++) begin
      hist_left[k]  = hist_left[k+1];
      hist_right[k] = hist_right[k+1];
    end
    hist_left[3]  = s.left_sample;
    hist_right[3] = s.right_sample;

    // Pass-through: one unchanged copy, offset untouched, history still shifts.
    if (pass_through) begin
      run_outputs[0] = '{left_out: s.left_sample, right_out: s.right_sample, last_of_run: 1'b1};
      return 1;
    end

    while (offset < one_unit && n < MAX_UPSAMPLE) begin
      frac = offset & (one_unit - 1);
      t    = longint'((frac << T_BITS) >> FRAC_BITS);
      run_outputs[n].left_out    = catmull_rom(hist_left, t);
      run_outputs[n].right_out   = catmull_rom(hist_right, t);
      run_outputs[n].last_of_run = 1'b0;
      n++;
      offset += ratio_step;
    end
    if (n > 0) begin
      run_outputs[n-1].last_of_run = 1'b1;
    end
    // One input consumed; if the cap stopped the run short of 1.0 the offset restarts at 0.
    if (offset >= one_unit) begin
      offset -= one_unit;
    end else begin
      offset = 0;
    end
    read_offset = offset[31:0];
    return n;
  endfunction

  function automatic audio_t random_audio();
    case ($urandom_range(0, 7))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return audio_t'(int'($urandom_range(0, 1023)) - 512);
      default: return audio_t'($urandom);
    endcase
  endfunction

  // Stops sending and waits until every expected output has arrived, then lets extra_cycles
  // pass so that an input that causes no output has also finished inside the block.
  task automatic drain(input int extra_cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) begin
      @(negedge clk);
    end
    repeat (extra_cycles) @(negedge clk);
  endtask

  // Register write; only called while the block is idle, so the predictor follows at once.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    if (index == CFG_RATIO_STEP) begin
      ratio_step = value[RATIO_W-1:0];
    end else if (index == CFG_PASS_THROUGH) begin
      pass_through = value[0];
    end
    register_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sends one sample as an input transfer, with random idle cycles in front of it. Valid is
  // left high on return so that a back-to-back transfer keeps it high without a dip.
  task automatic send_sample(input cir_in_t s, input bit known, input cir_out_t known_output);
    int n;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    n = resample_sample(s);
    if (known) begin
      expected_outputs.push_back(known_output);
    end else begin
      for (int k = 0; k < n; k++) begin
        expected_outputs.push_back(run_outputs[k]);
      end
    end
    samples_sent++;
  endtask

  task automatic report_mismatch(input string field, input longint want, input longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // The receiver stalls at random at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Scoreboard: every output transfer is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        errors++;
        $display("%0t: output transfer with nothing expected, actual %0d %0d last %0b",
                 $time, out_data.left_out, out_data.right_out, out_data.last_of_run);
      end else begin
        oldest_expected = expected_outputs.pop_front();
        outputs_checked++;
        if (out_data.left_out !== oldest_expected.left_out) begin
          report_mismatch("left_out", oldest_expected.left_out, out_data.left_out);
        end
        if (out_data.right_out !== oldest_expected.right_out) begin
          report_mismatch("right_out", oldest_expected.right_out, out_data.right_out);
        end
        if (out_data.last_of_run !== oldest_expected.last_of_run) begin
          report_mismatch("last_of_run", oldest_expected.last_of_run, out_data.last_of_run);
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost output ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cubic_interpolating_resampler_unit_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [RATIO_W-1:0] new_ratio;
    logic               new_pass;

    // Predictor state after reset.
    for (int k = 0; k < 4; k++) begin
      hist_left[k]  = ZERO;
      hist_right[k] = ZERO;
    end
    read_offset  = '0;
    ratio_step   = RATIO_RESET;
    pass_through = 1'b0;

    // Directed table. The first sample after reset lands in the newest history slot while the
    // interpolation runs between the two older, still zero, slots at weight 0, so it yields a
    // single zero output. In pass-through the one output is the input itself.
    directed_rows.push_back('{ROW_KNOWN, '0, '0, {FULL_POS, FULL_NEG}, {ZERO, ZERO, 1'b1}});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {FULL_NEG, FULL_POS}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {FULL_POS, FULL_NEG}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {FULL_NEG, FULL_POS}, '0});
    // Lowest ratio in range: eight outputs per input, and alternating full-scale samples
    // overshoot between the points, which forces saturation.
    directed_rows.push_back('{ROW_CONFIG, CFG_RATIO_STEP, RATIO_LOW, '0, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {FULL_POS, FULL_NEG}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {FULL_NEG, FULL_POS}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {FULL_POS, FULL_NEG}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {ZERO, MINUS1}, '0});
    // Highest ratio: strong downsampling, most inputs give no output at all.
    directed_rows.push_back('{ROW_CONFIG, CFG_RATIO_STEP, RATIO_HIGH, '0, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {24'sd123456, -24'sd654321}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {FULL_NEG, FULL_NEG}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {FULL_POS, FULL_POS}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {-24'sd77, 24'sd4095}, '0});
    // Ratios below range, down to zero. The offset left by the highest ratio is still above
    // 1.0 here, so these inputs give no output and the output cap is not reached.
    directed_rows.push_back('{ROW_CONFIG, CFG_RATIO_STEP, RATIO_SLOW, '0, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {24'sd2000000, -24'sd3000000}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {-24'sd1234567, 24'sd7654321}, '0});
    directed_rows.push_back('{ROW_CONFIG, CFG_RATIO_STEP, 28'd0, '0, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {FULL_POS, ZERO}, '0});
    // A write to an unmapped index changes nothing.
    directed_rows.push_back('{ROW_CONFIG, CFG_UNMAPPED_HIGH, 28'hFFFFFFF, '0, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {ZERO, FULL_NEG}, '0});
    // Pass-through on, then off through a value whose upper bits are masked away.
    directed_rows.push_back('{ROW_CONFIG, CFG_PASS_THROUGH, 28'd1, '0, '0});
    directed_rows.push_back('{ROW_KNOWN, '0, '0, {FULL_POS, FULL_NEG}, {FULL_POS, FULL_NEG, 1'b1}});
    directed_rows.push_back('{ROW_KNOWN, '0, '0, {FULL_NEG, FULL_POS}, {FULL_NEG, FULL_POS, 1'b1}});
    directed_rows.push_back('{ROW_KNOWN, '0, '0, {ZERO, MINUS1}, {ZERO, MINUS1, 1'b1}});
    directed_rows.push_back('{ROW_CONFIG, CFG_PASS_THROUGH, 28'hFFFFFFE, '0, '0});
    directed_rows.push_back('{ROW_CONFIG, CFG_RATIO_STEP, 28'd12582912, '0, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {24'sd4000000, 24'sd100}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {-24'sd4000000, -24'sd100}, '0});
    directed_rows.push_back('{ROW_SAMPLE, '0, '0, {MINUS1, 24'sd1}, '0});
    directed_rows.push_back('{ROW_CONFIG, CFG_RATIO_STEP, RATIO_RESET, '0, '0});

    // Reset once, released on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = sender_idle_by_phase[0];
    stall_pct       = stall_by_phase[0];
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        drain(SETTLE_CYCLES);
        write_register(directed_rows[i].index, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].sample, directed_rows[i].kind == ROW_KNOWN,
                    directed_rows[i].known);
      end
    end

    // Random part: three idling phases, each split into segments with a fresh setting.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = sender_idle_by_phase[phase];
      stall_pct       = stall_by_phase[phase];
      for (int seg = 0; seg < 4; seg++) begin
        drain(SETTLE_CYCLES);
        case ($urandom_range(0, 5))
          0:       new_ratio = RATIO_LOW;
          1:       new_ratio = RATIO_HIGH;
          2:       new_ratio = RATIO_RESET;
          3:       new_ratio = RATIO_W'($urandom_range(0, RATIO_LOW - 1));
          default: new_ratio = RATIO_W'($urandom_range(RATIO_LOW, RATIO_HIGH));
        endcase
        new_pass = ($urandom_range(0, 4) == 0);
        write_register(CFG_RATIO_STEP, new_ratio);
        // Upper data bits are random; only bit 0 reaches the register.
        write_register(CFG_PASS_THROUGH, {(CFG_DATA_W-1)'($urandom), new_pass});
        if ($urandom_range(0, 3) == 0) begin
          write_register($urandom_range(0, 1) ? CFG_UNMAPPED_LOW : CFG_UNMAPPED_HIGH,
                         CFG_DATA_W'($urandom));
        end
        for (int k = 0; k < 9; k++) begin
          // Once per phase the sender holds off until every expected output has arrived.
          if (seg == 1 && k == 6) begin
            drain(0);
            drain_pauses++;
          end
          send_sample({random_audio(), random_audio()}, 1'b0, '0);
        end
      end
    end

    drain(SETTLE_CYCLES);
    $display("Sent %0d samples with %0d register writes; checked %0d output transfers.",
             samples_sent, register_writes, outputs_checked);
    $display("Covered ratio extremes, output cap, downsampling, pass-through, %0d drain pauses.",
             drain_pauses);
    if (errors == 0) begin
      $display("cubic_interpolating_resampler_unit_test: clean");
    end else begin
      $display("cubic_interpolating_resampler_unit_test: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cir_pkg.sv
rtl/cir_lane.sv
rtl/cir_merge.sv
rtl/cubic_interpolating_resampler_unit.sv
sim/cubic_interpolating_resampler_unit_test.sv
